@@ hw/rtl/mrp_pkg.sv @@
// Shared types and constants for the measurement record parser.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package mrp_pkg;

    // Characters that follow a data tag.
    localparam int unsigned FIELD_DIGITS = 4;
    localparam int unsigned CNT_W        = 3;

    localparam int unsigned VAL_W   = 14;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned BMI_W   = 31;
    localparam int unsigned KIND_W  = 2;

    // Index arithmetic: numerator 2*w*1e6 + h*h, divisor 2*h*h.
    localparam int unsigned NUM_W    = 35;
    localparam int unsigned SQ_W     = 28;
    localparam int unsigned DIV_W    = 29;
    localparam int unsigned DCNT_W   = 6;
    localparam int unsigned ACC_W    = 18;

    localparam logic [20:0]        SCALE_X2 = 21'd2000000;
    localparam logic [VAL_W-1:0]   VAL_MAX  = 14'd16383;
    localparam logic [BMI_W-1:0]   BMI_MAX  = 31'h7fff_ffff;

    localparam logic [BYTE_W-1:0] CH_0 = 8'h30;
    localparam logic [BYTE_W-1:0] CH_2 = 8'h32;
    localparam logic [BYTE_W-1:0] CH_3 = 8'h33;
    localparam logic [BYTE_W-1:0] CH_4 = 8'h34;
    localparam logic [BYTE_W-1:0] CH_7 = 8'h37;
    localparam logic [BYTE_W-1:0] CH_9 = 8'h39;

    localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FOOT   = 2'd1;

    typedef struct packed {
        logic tag_load;
        logic digit;
        logic mul;
        logic add;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic data_tag;
        logic index_tag;
        logic skip_tag;
        logic last_char;
        logic h_zero;
        logic div_last;
    } t_status;

endpackage

`default_nettype wire

@@ hw/rtl/mrp_ctrl.sv @@
// Controller for the measurement record parser: record phase tracking,
// index computation sequencing and the output valid flag. Uses mrp_pkg.
`default_nettype none

module mrp_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    input  mrp_pkg::t_status i_status,
    output mrp_pkg::t_cmd    o_cmd
);
    import mrp_pkg::*;

    typedef enum logic [2:0] {
        PH_TAG    = 3'b001,
        PH_DIGITS = 3'b010,
        PH_SKIP   = 3'b100
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ADD  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_phase r_phase, n_phase;
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_accept;
    logic   out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        n_phase = r_phase;
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (r_phase)
                        PH_DIGITS: begin
                            o_cmd.digit = 1'b1;
                            if (i_status.last_char) begin
                                n_phase = PH_SKIP;
                            end
                        end
                        PH_SKIP: n_phase = PH_TAG;
                        PH_TAG: begin
                            priority if (i_status.data_tag) begin
                                o_cmd.tag_load = 1'b1;
                                n_phase        = PH_DIGITS;
                            end else if (i_status.index_tag) begin
                                n_phase = PH_SKIP;
                                n_state = S_MUL;
                            end else if (i_status.skip_tag) begin
                                n_phase = PH_SKIP;
                            end else begin
                                // Unknown tags are dropped.
                                n_phase = PH_TAG;
                            end
                        end
                        default: n_phase = PH_TAG;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = i_status.h_zero ? S_DONE : S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TAG;
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a pending transaction");

    // An index tag accepted in tag phase starts the computation.
    a_index_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == PH_TAG && i_status.index_tag) |=> (r_state == S_MUL))
        else $error("index tag did not start the computation");

    // The divider only leaves its loop toward the output stage.
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_DIV || r_state == S_DONE))
        else $error("divider loop left unexpectedly");

    // Input is held off for the whole computation.
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> o_in_stall)
        else $error("input accepted during index computation");

endmodule

`default_nettype wire

@@ hw/rtl/mrp_datapath.sv @@
// Datapath for the measurement record parser: digit accumulation, stored
// values, index multiply, restoring divider and output register. Uses mrp_pkg.
`default_nettype none

module mrp_datapath (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  [mrp_pkg::BYTE_W-1:0]  i_rx_byte,
    input  mrp_pkg::t_cmd               i_cmd,
    output mrp_pkg::t_status            o_status,
    output logic [mrp_pkg::BMI_W-1:0]   o_bmi,
    output logic                        o_bmi_valid,
    output logic                        o_bmi_saturated,
    output logic [mrp_pkg::VAL_W-1:0]   o_weight,
    output logic [mrp_pkg::VAL_W-1:0]   o_height,
    output logic [mrp_pkg::VAL_W-1:0]   o_foot
);
    import mrp_pkg::*;

    logic [KIND_W-1:0] r_kind;
    logic [CNT_W-1:0]  r_char_count;
    logic [CNT_W-1:0]  n_char_count;
    logic [VAL_W-1:0]  r_acc, n_acc;
    logic              r_stopped;
    logic [VAL_W-1:0]  r_weight, r_height, r_foot;
    logic [BMI_W-1:0]  r_index, n_index;

    logic [NUM_W-1:0]  r_wprod;
    logic [SQ_W-1:0]   r_h2;
    logic [NUM_W-1:0]  r_quo;
    logic [DIV_W-1:0]  r_divisor;
    logic [DIV_W-1:0]  r_rem;
    logic [DCNT_W-1:0] r_div_cnt;

    logic [BMI_W-1:0]  r_bmi;
    logic              r_bmi_valid, r_bmi_sat;
    logic [VAL_W-1:0]  r_out_weight, r_out_height, r_out_foot;

    logic              is_digit;
    logic [3:0]        digit_val;
    logic [ACC_W-1:0]  acc_sum;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    trial_diff;
    logic              quo_sat;

    assign is_digit  = (i_rx_byte >= CH_0) && (i_rx_byte <= CH_9);
    assign digit_val = 4'(i_rx_byte - CH_0);
    assign acc_sum   = ACC_W'(r_acc) * ACC_W'(10) + ACC_W'(digit_val);

    always_comb begin
        n_acc = r_acc;
        if (!r_stopped && is_digit) begin
            n_acc = (acc_sum > ACC_W'(VAL_MAX)) ? VAL_MAX : acc_sum[VAL_W-1:0];
        end
    end

    assign n_char_count = r_char_count + CNT_W'(1);

    // One restoring step: bring down the next numerator bit, subtract if it fits.
    assign trial      = {r_rem, r_quo[NUM_W-1]};
    assign trial_diff = trial - {1'b0, r_divisor};

    assign quo_sat = (r_quo[NUM_W-1:BMI_W] != '0);
    assign n_index = o_status.h_zero ? r_index : (quo_sat ? BMI_MAX : r_quo[BMI_W-1:0]);

    always_comb begin
        o_status.data_tag  = (i_rx_byte >= CH_0) && (i_rx_byte <= CH_2);
        o_status.index_tag = (i_rx_byte == CH_3);
        o_status.skip_tag  = (i_rx_byte >= CH_4) && (i_rx_byte <= CH_7);
        o_status.last_char = (n_char_count >= CNT_W'(FIELD_DIGITS));
        o_status.h_zero    = (r_height == '0);
        o_status.div_last  = (r_div_cnt == DCNT_W'(NUM_W - 1));
    end

    // Parser and measurement state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind       <= '0;
            r_char_count <= '0;
            r_acc        <= '0;
            r_stopped    <= 1'b0;
            r_weight     <= '0;
            r_height     <= '0;
            r_foot       <= '0;
            r_index      <= '0;
        end else begin
            if (i_cmd.tag_load) begin
                r_kind       <= KIND_W'(i_rx_byte - CH_0);
                r_char_count <= '0;
                r_acc        <= '0;
                r_stopped    <= 1'b0;
            end
            if (i_cmd.digit) begin
                r_acc        <= n_acc;
                r_char_count <= n_char_count;
                if (!(!r_stopped && is_digit)) begin
                    r_stopped <= 1'b1;
                end
                if (o_status.last_char) begin
                    priority if (r_kind == KIND_WEIGHT) begin
                        r_weight <= n_acc;
                    end else if (r_kind == KIND_FOOT) begin
                        r_foot <= n_acc;
                    end else begin
                        r_height <= n_acc;
                    end
                end
            end
            if (i_cmd.load_out) begin
                r_index <= n_index;
            end
        end
    end

    // Index arithmetic; payload only, sequenced by the controller.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_wprod <= NUM_W'(r_weight) * NUM_W'(SCALE_X2);
            r_h2    <= SQ_W'(r_height) * SQ_W'(r_height);
        end
        if (i_cmd.add) begin
            r_quo     <= r_wprod + NUM_W'(r_h2);
            r_divisor <= {r_h2, 1'b0};
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + DCNT_W'(1);
            if (!trial_diff[DIV_W]) begin
                r_rem <= trial_diff[DIV_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[DIV_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b0};
            end
        end
    end

    // Output register, loaded only when the previous transaction is gone.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_bmi        <= n_index;
            r_bmi_valid  <= !o_status.h_zero;
            r_bmi_sat    <= !o_status.h_zero && quo_sat;
            r_out_weight <= r_weight;
            r_out_height <= r_height;
            r_out_foot   <= r_foot;
        end
    end

    assign o_bmi           = r_bmi;
    assign o_bmi_valid     = r_bmi_valid;
    assign o_bmi_saturated = r_bmi_sat;
    assign o_weight        = r_out_weight;
    assign o_height        = r_out_height;
    assign o_foot          = r_out_foot;

    // A saturated index is always reported at the top of the range.
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && !o_status.h_zero && quo_sat) |=> (r_index == BMI_MAX))
        else $error("saturated index not clamped");

    // Height zero keeps the previous index.
    a_keep_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && o_status.h_zero) |=> (r_index == $past(r_index)))
        else $error("index changed with zero height");

    // The remainder stays below the divisor throughout the division.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.div_step) |-> (r_rem < r_divisor))
        else $error("divider remainder out of range");

endmodule

`default_nettype wire

@@ hw/rtl/measurement_record_parser.sv @@
// Measurement record parser: a data byte or skip byte is taken without stalling; input stalls while
// the index is computed and while its result waits for the output to take it.
// An index tag reaches o_out_valid through multiply, add, a 35-step restoring divider and the
// output load; at height zero the add and the divider are skipped.
// Sustained rate: one byte per cycle while no index record holds the input stalled.
// Synchronous active-low reset returns the parser to awaiting a tag with stored weight, height, foot and index zero.
`default_nettype none

module measurement_record_parser (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire  [mrp_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic [mrp_pkg::BMI_W-1:0]   o_bmi,
    output logic                        o_bmi_valid,
    output logic                        o_bmi_saturated,
    output logic [mrp_pkg::VAL_W-1:0]   o_weight,
    output logic [mrp_pkg::VAL_W-1:0]   o_height,
    output logic [mrp_pkg::VAL_W-1:0]   o_foot
);
    import mrp_pkg::*;

    t_cmd    cmd;
    t_status status;

    mrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mrp_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_byte       (i_rx_byte),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_bmi           (o_bmi),
        .o_bmi_valid     (o_bmi_valid),
        .o_bmi_saturated (o_bmi_saturated),
        .o_weight        (o_weight),
        .o_height        (o_height),
        .o_foot          (o_foot)
    );

endmodule

`default_nettype wire
